// ===== src/rmug_pkg.sv =====
// Shared types and constants for the RC4 monotonic ULID generator.
// Depends on nothing; the top level refers to it by scoped names.
package rmug_pkg;

  localparam int PermDepth = 256;
  localparam int PermAw    = 8;
  localparam int ByteW     = 8;
  localparam int TsW       = 48;
  localparam int RndW      = 80;
  localparam int UlidW     = 130;
  localparam int GroupW    = 5;
  localparam int CharW     = 7;
  localparam int IdxW      = 5;
  localparam int CntW      = 4;

  localparam logic [IdxW-1:0] LastCharIdx  = 5'd25;
  localparam logic [CntW-1:0] LastRndByte  = 4'd9;

  localparam logic [0:0] CfgRelaxed  = 1'b0;
  localparam logic [0:0] CfgParanoid = 1'b1;

  localparam logic FuncKey      = 1'b0;
  localparam logic FuncGenerate = 1'b1;

  localparam logic [CharW-1:0] Crockford [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4d, 7'h4e, 7'h50, 7'h51,
    7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5a
  };

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StKeyJ,
    StKeyW1,
    StKeyW2,
    StGenRdJ,
    StGenSwap,
    StGenFin,
    StEmit
  } state_e;

endpackage

// ===== src/rc4_monotonic_ulid_generator.sv =====
// Top level of the RC4 monotonic ULID generator.
// Depends on rmug_pkg and rmug_ram (the RC4 permutation memory).
//
// Input channel (in_valid_i/in_ready_o): func_i 0 mixes key_byte_i into the
// RC4 permutation as one key-schedule step; func_i 1 generates an identifier
// for timestamp_ms_i. Output channel (out_valid_o/out_ready_i): a generate
// item yields 26 transfers, one Crockford base32 character each, most
// significant first, each with char_index_o, and last_char_o on the final one.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 relaxed mode, 1 paranoid mode); write only while idle.
// After reset the permutation memory is set to the identity, one entry a
// cycle, so the input channel stays not ready until every entry is written.
// A key item runs StKeyJ, StKeyW1 and StKeyW2. A generate item with an
// unchanged timestamp, outside relaxed mode, goes straight to output; any
// other runs StGenRdJ, StGenSwap and StGenFin for each of ten fresh random
// bytes, as each RC4 byte costs three accesses of the single-read permutation
// memory. One item at a time; input is not ready while characters are sent.
// A stalled receiver holds the character, halting the block, until taken.
module rc4_monotonic_ulid_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [0:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [rmug_pkg::ByteW-1:0]   key_byte_i,
  input  logic [rmug_pkg::TsW-1:0]     timestamp_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rmug_pkg::CharW-1:0]   char_code_o,
  output logic [rmug_pkg::IdxW-1:0]    char_index_o,
  output logic                         last_char_o
);

  rmug_pkg::state_e state_q, state_d;

  logic [rmug_pkg::PermAw-1:0] init_cnt_q, init_cnt_d;
  logic [rmug_pkg::ByteW-1:0]  i_q, i_d, j_q, j_d;
  logic [rmug_pkg::ByteW-1:0]  kstep_q, kstep_d, kacc_q, kacc_d;
  logic [rmug_pkg::TsW-1:0]    ts_q, ts_d;
  logic [rmug_pkg::RndW-1:0]   rnd_q, rnd_d;
  logic [rmug_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                        relaxed_q, paranoid_q;
  logic                        fw_q, fw_d;

  logic [rmug_pkg::ByteW-1:0]  si_q, si_d, t_q, t_d, kb_q, kb_d, fwdata_q;
  logic [rmug_pkg::CntW-1:0]   bcnt_q, bcnt_d;
  logic [rmug_pkg::UlidW-1:0]  sh_q, sh_d;

  logic                        ram_we;
  logic [rmug_pkg::PermAw-1:0] ram_waddr, ram_raddr;
  logic [rmug_pkg::ByteW-1:0]  ram_wdata, ram_rdata, rd;

  logic                        in_xfer, out_xfer, same_ms;
  logic [rmug_pkg::ByteW-1:0]  sum_j, out_byte;
  logic [rmug_pkg::RndW-1:0]   rnd_inc, rnd_new, rnd_fin;

  rmug_ram #(
    .Width(rmug_pkg::ByteW),
    .Depth(rmug_pkg::PermDepth)
  ) u_perm (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd       = fw_q ? fwdata_q : ram_rdata;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign same_ms  = !relaxed_q && (timestamp_ms_i == ts_q);
  assign rnd_inc  = rnd_q + rmug_pkg::RndW'(1);
  assign out_byte = (t_q == j_q) ? si_q : rd;
  assign rnd_new  = {rnd_q[rmug_pkg::RndW-rmug_pkg::ByteW-1:0], out_byte};
  assign rnd_fin  = {rnd_new[rmug_pkg::RndW-1] & ~paranoid_q, rnd_new[rmug_pkg::RndW-2:0]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmug_pkg::StInit: begin
        if (init_cnt_q == rmug_pkg::PermAw'(rmug_pkg::PermDepth - 1)) begin
          state_d = rmug_pkg::StIdle;
        end
      end
      rmug_pkg::StIdle: begin
        if (in_xfer) begin
          if (func_i == rmug_pkg::FuncKey) begin
            state_d = rmug_pkg::StKeyJ;
          end else if (same_ms) begin
            state_d = rmug_pkg::StEmit;
          end else begin
            state_d = rmug_pkg::StGenRdJ;
          end
        end
      end
      rmug_pkg::StKeyJ:    state_d = rmug_pkg::StKeyW1;
      rmug_pkg::StKeyW1:   state_d = rmug_pkg::StKeyW2;
      rmug_pkg::StKeyW2:   state_d = rmug_pkg::StIdle;
      rmug_pkg::StGenRdJ:  state_d = rmug_pkg::StGenSwap;
      rmug_pkg::StGenSwap: state_d = rmug_pkg::StGenFin;
      rmug_pkg::StGenFin: begin
        state_d = (bcnt_q == rmug_pkg::LastRndByte) ? rmug_pkg::StEmit : rmug_pkg::StGenRdJ;
      end
      rmug_pkg::StEmit: begin
        if (out_xfer && (idx_q == rmug_pkg::LastCharIdx)) begin
          state_d = rmug_pkg::StIdle;
        end
      end
      default: state_d = rmug_pkg::StInit;
    endcase
  end

  always_comb begin
    init_cnt_d = init_cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    kstep_d    = kstep_q;
    kacc_d     = kacc_q;
    ts_d       = ts_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    si_d       = si_q;
    t_d        = t_q;
    kb_d       = kb_q;
    bcnt_d     = bcnt_q;
    sh_d       = sh_q;
    sum_j      = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    unique case (state_q)
      rmug_pkg::StInit: begin
        ram_we     = 1'b1;
        ram_waddr  = init_cnt_q;
        ram_wdata  = init_cnt_q;
        init_cnt_d = init_cnt_q + rmug_pkg::PermAw'(1);
      end
      rmug_pkg::StIdle: begin
        ram_raddr = (func_i == rmug_pkg::FuncKey) ? kstep_q : i_q + rmug_pkg::ByteW'(1);
        kb_d      = key_byte_i;
        bcnt_d    = '0;
        if (in_xfer && (func_i == rmug_pkg::FuncGenerate)) begin
          if (same_ms) begin
            rnd_d = rnd_inc;
            sh_d  = {2'b00, ts_q, rnd_inc};
            idx_d = '0;
          end else begin
            ts_d = timestamp_ms_i;
            i_d  = i_q + rmug_pkg::ByteW'(1);
          end
        end
      end
      rmug_pkg::StKeyJ: begin
        sum_j     = kacc_q + rd + kb_q;
        si_d      = rd;
        kacc_d    = sum_j;
        ram_raddr = sum_j;
      end
      rmug_pkg::StKeyW1: begin
        ram_we    = 1'b1;
        ram_waddr = kstep_q;
        ram_wdata = rd;
      end
      rmug_pkg::StKeyW2: begin
        ram_we    = 1'b1;
        ram_waddr = kacc_q;
        ram_wdata = si_q;
        kstep_d   = kstep_q + rmug_pkg::ByteW'(1);
      end
      rmug_pkg::StGenRdJ: begin
        sum_j     = j_q + rd;
        si_d      = rd;
        j_d       = sum_j;
        ram_raddr = sum_j;
      end
      rmug_pkg::StGenSwap: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = rd;
        t_d       = si_q + rd;
        ram_raddr = si_q + rd;
      end
      rmug_pkg::StGenFin: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        if (bcnt_q == rmug_pkg::LastRndByte) begin
          rnd_d = rnd_fin;
          sh_d  = {2'b00, ts_q, rnd_fin};
          idx_d = '0;
        end else begin
          rnd_d     = rnd_new;
          bcnt_d    = bcnt_q + rmug_pkg::CntW'(1);
          i_d       = i_q + rmug_pkg::ByteW'(1);
          ram_raddr = i_q + rmug_pkg::ByteW'(1);
        end
      end
      rmug_pkg::StEmit: begin
        if (out_xfer) begin
          sh_d  = sh_q << rmug_pkg::GroupW;
          idx_d = idx_q + rmug_pkg::IdxW'(1);
        end
      end
      default: begin
        init_cnt_d = '0;
      end
    endcase
  end

  assign fw_d = ram_we && (ram_waddr == ram_raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rmug_pkg::StInit;
      init_cnt_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      kstep_q    <= '0;
      kacc_q     <= '0;
      ts_q       <= '0;
      rnd_q      <= '0;
      idx_q      <= '0;
      fw_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      kstep_q    <= kstep_d;
      kacc_q     <= kacc_d;
      ts_q       <= ts_d;
      rnd_q      <= rnd_d;
      idx_q      <= idx_d;
      fw_q       <= fw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relaxed_q  <= 1'b0;
      paranoid_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmug_pkg::CfgRelaxed:  relaxed_q  <= cfg_wdata_i[0];
        rmug_pkg::CfgParanoid: paranoid_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    si_q     <= si_d;
    t_q      <= t_d;
    kb_q     <= kb_d;
    bcnt_q   <= bcnt_d;
    sh_q     <= sh_d;
    fwdata_q <= ram_wdata;
  end

  assign in_ready_o   = (state_q == rmug_pkg::StIdle);
  assign out_valid_o  = (state_q == rmug_pkg::StEmit);
  assign char_code_o  = rmug_pkg::Crockford[sh_q[rmug_pkg::UlidW-1 -: rmug_pkg::GroupW]];
  assign char_index_o = idx_q;
  assign last_char_o  = (idx_q == rmug_pkg::LastCharIdx);

endmodule

// ===== src/rmug_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// A read at the address being written returns the old contents.
module rmug_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rmug_checker.sv =====
// Port-level assertions for the RC4 monotonic ULID generator.
// Depends on the top level's ports only; bound to it at the end of this file.
module rmug_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] char_code_o,
  input logic [4:0] char_index_o,
  input logic       last_char_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o)
      && $stable(char_index_o))
    else $error("stalled character changed");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while characters are pending");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_char_o |=> out_valid_o
      && (char_index_o == $past(char_index_o) + 5'd1))
    else $error("character sequence broken");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_char_o |=> !out_valid_o && in_ready_o)
    else $error("block not idle after the final character");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_char_o == (char_index_o == 5'd25)))
    else $error("last character flag misplaced");

endmodule

bind rc4_monotonic_ulid_generator rmug_checker u_rmug_checker (.*);
